FILE: src/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

	localparam int unsigned MAX_PATTERN = 8;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned PAT_W       = MAX_PATTERN * BYTE_W;
	localparam int unsigned LEN_W       = 4;
	localparam int unsigned CNT_W       = $clog2(MAX_PATTERN + 1);
	localparam int unsigned IDX_W       = $clog2(MAX_PATTERN);
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = PAT_W;

	typedef logic [BYTE_W-1:0] byte_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_REPL    = CFG_IDX_W'(2);

	// Register values after reset: pattern "++", length two, replacement '^'.
	localparam logic [PAT_W-1:0]  RST_PATTERN = PAT_W'(64'd11051);
	localparam logic [LEN_W-1:0]  RST_LENGTH  = LEN_W'(2);
	localparam byte_t             RST_REPL    = BYTE_W'(94);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: src/ssr_in_if.sv
`default_nettype none

interface ssr_in_if;
	logic          valid;
	logic          ready;
	ssr_pkg::byte_t in_byte;
	logic          line_end;

	modport source (output valid, output in_byte, output line_end, input ready);
	modport sink (input valid, input in_byte, input line_end, output ready);
endinterface

`default_nettype wire

FILE: src/ssr_out_if.sv
`default_nettype none

interface ssr_out_if;
	logic          valid;
	logic          ready;
	ssr_pkg::byte_t out_byte;
	logic          has_byte;
	logic          out_line_end;
	logic          last_of_run;

	modport source (output valid, output out_byte, output has_byte, output out_line_end,
		output last_of_run, input ready);
	modport sink (input valid, input out_byte, input has_byte, input out_line_end,
		input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/stream_substring_replace.sv
`default_nettype none

// Streaming substring replacement. Text enters one byte per beat on rx, with line_end
// marking the last byte of a line. Every leftmost, non-overlapping occurrence of the
// configured pattern (one to eight bytes, first byte in the low bits of register 0,
// length in register 1) is replaced by the single byte of register 2; a length of zero
// disables matching and a length above eight acts as eight. The replacement byte stays
// at the head of the pending window and can take part in a further match, except when
// a one-byte pattern equals its replacement, in which case it is emitted once. Results
// leave on tx one byte per beat; last_of_run marks the final beat caused by an input
// beat, and out_line_end the final beat of a line. A line end that leaves nothing to
// emit produces one empty beat with has_byte low. An input beat that emits nothing and
// ends no line produces no beat at all. One input beat is handled at a time by a small
// sequencer that drives a single window compare and shift unit: it takes the beat, then
// runs the matching loop step by step (each emitted byte and each replacement is one
// step, plus one step that decides the window may wait or finds it empty), then closes
// the item. A line end that flushes a waiting prefix adds one more step that finds the
// flushed window empty. Loop steps and the closing step wait while tx is stalled.
// Registers should be written only while the block is idle.
module stream_substring_replace (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data,
	ssr_in_if.sink                               rx,
	ssr_out_if.source                            tx
);

	localparam int unsigned MAXP = ssr_pkg::MAX_PATTERN;
	localparam int unsigned BW   = ssr_pkg::BYTE_W;
	localparam int unsigned CW   = ssr_pkg::CNT_W;
	localparam int unsigned LW   = ssr_pkg::LEN_W;
	localparam int unsigned IW   = ssr_pkg::IDX_W;

	// Configuration registers.
	logic [ssr_pkg::PAT_W-1:0] pattern_q;
	logic [LW-1:0]             plen_q;
	ssr_pkg::byte_t            repl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= ssr_pkg::RST_PATTERN;
			plen_q    <= ssr_pkg::RST_LENGTH;
			repl_q    <= ssr_pkg::RST_REPL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssr_pkg::REG_PATTERN: pattern_q <= cfg_data;
				ssr_pkg::REG_LENGTH:  plen_q    <= cfg_data[LW-1:0];
				ssr_pkg::REG_REPL:    repl_q    <= cfg_data[BW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and window state.
	ssr_pkg::state_t state_q, state_d;
	ssr_pkg::byte_t  win_q [MAXP];
	ssr_pkg::byte_t  win_d [MAXP];
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            eol_q, eol_d;

	// The most recent emitted byte is held back one step, so that it can be marked as
	// the last of its run once the loop is known to have finished.
	logic            hold_v_q, hold_v_d;
	ssr_pkg::byte_t  hold_q, hold_d;

	// Output register.
	logic            ov_q, ov_d;
	ssr_pkg::byte_t  ob_q, ob_d;
	logic            ohas_q, ohas_d;
	logic            ole_q, ole_d;
	logic            olast_q, olast_d;

	logic            out_free;
	logic [LW-1:0]   len_eff;
	logic [MAXP-1:0] eq;
	logic            full_ok, part_ok;
	logic            full_match, part_match, keep_once;

	assign out_free = !ov_q || tx.ready;

	// Window compare unit: every window entry against its pattern byte.
	always_comb begin
		len_eff = (plen_q > LW'(MAXP)) ? LW'(MAXP) : plen_q;
		full_ok = 1'b1;
		part_ok = 1'b1;
		for (int i = 0; i < MAXP; i++) begin
			eq[i] = (win_q[i] == pattern_q[i*BW +: BW]);
			if (LW'(i) < len_eff && !eq[i]) begin
				full_ok = 1'b0;
			end
			if (CW'(i) < cnt_q && !eq[i]) begin
				part_ok = 1'b0;
			end
		end
		full_match = (len_eff != '0) && (CW'(len_eff) <= cnt_q) && full_ok;
		part_match = (len_eff != '0) && (cnt_q < CW'(len_eff)) && part_ok;
		// A one-byte pattern equal to its replacement would match forever; it leaves the
		// window as an ordinary byte instead. The head byte then equals the replacement.
		keep_once  = (len_eff == LW'(1)) && (repl_q == pattern_q[BW-1:0]);
	end

	always_comb begin
		logic          do_pop;
		logic          do_repl;
		logic [LW:0]   sidx;

		state_d  = state_q;
		win_d    = win_q;
		cnt_d    = cnt_q;
		eol_d    = eol_q;
		hold_v_d = hold_v_q;
		hold_d   = hold_q;
		ov_d     = ov_q && !tx.ready;
		ob_d     = ob_q;
		ohas_d   = ohas_q;
		ole_d    = ole_q;
		olast_d  = olast_q;
		do_pop   = 1'b0;
		do_repl  = 1'b0;
		sidx     = '0;

		unique case (state_q)
			ssr_pkg::ST_IDLE: begin
				if (rx.valid) begin
					// The window never holds more than seven bytes between items.
					win_d[cnt_q[IW-1:0]] = rx.in_byte;
					cnt_d   = cnt_q + CW'(1);
					eol_d   = rx.line_end;
					state_d = ssr_pkg::ST_RUN;
				end
			end
			ssr_pkg::ST_RUN: begin
				if (out_free) begin
					priority if (cnt_q == '0) begin
						state_d = ssr_pkg::ST_DONE;
					end else if (full_match && !keep_once) begin
						do_repl = 1'b1;
					end else if (full_match) begin
						do_pop = 1'b1;
					end else if (part_match) begin
						state_d = eol_q ? ssr_pkg::ST_FLUSH : ssr_pkg::ST_DONE;
					end else begin
						do_pop = 1'b1;
					end
				end
			end
			ssr_pkg::ST_FLUSH: begin
				if (out_free) begin
					if (cnt_q == '0) begin
						state_d = ssr_pkg::ST_DONE;
					end else begin
						do_pop = 1'b1;
					end
				end
			end
			ssr_pkg::ST_DONE: begin
				if (out_free) begin
					if (hold_v_q) begin
						ov_d    = 1'b1;
						ob_d    = hold_q;
						ohas_d  = 1'b1;
						ole_d   = eol_q;
						olast_d = 1'b1;
					end else if (eol_q) begin
						ov_d    = 1'b1;
						ob_d    = '0;
						ohas_d  = 1'b0;
						ole_d   = 1'b1;
						olast_d = 1'b1;
					end
					hold_v_d = 1'b0;
					state_d  = ssr_pkg::ST_IDLE;
				end
			end
			default: state_d = ssr_pkg::ST_IDLE;
		endcase

		if (do_pop) begin
			if (hold_v_q) begin
				ov_d    = 1'b1;
				ob_d    = hold_q;
				ohas_d  = 1'b1;
				ole_d   = 1'b0;
				olast_d = 1'b0;
			end
			hold_d   = win_q[0];
			hold_v_d = 1'b1;
			for (int i = 0; i < MAXP - 1; i++) begin
				win_d[i] = win_q[i+1];
			end
			cnt_d = cnt_q - CW'(1);
		end

		if (do_repl) begin
			// The matched prefix collapses into the replacement byte at the head.
			win_d[0] = repl_q;
			for (int j = 1; j < MAXP; j++) begin
				sidx = (LW+1)'(j) + {1'b0, len_eff} - (LW+1)'(1);
				if (sidx < (LW+1)'(MAXP)) begin
					win_d[j] = win_q[sidx[IW-1:0]];
				end
			end
			cnt_d = cnt_q - CW'(len_eff) + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ssr_pkg::ST_IDLE;
			cnt_q    <= '0;
			eol_q    <= 1'b0;
			hold_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			eol_q    <= eol_d;
			hold_v_q <= hold_v_d;
			ov_q     <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		win_q   <= win_d;
		hold_q  <= hold_d;
		ob_q    <= ob_d;
		ohas_q  <= ohas_d;
		ole_q   <= ole_d;
		olast_q <= olast_d;
	end

	assign rx.ready        = (state_q == ssr_pkg::ST_IDLE);
	assign tx.valid        = ov_q;
	assign tx.out_byte     = ob_q;
	assign tx.has_byte     = ohas_q;
	assign tx.out_line_end = ole_q;
	assign tx.last_of_run  = olast_q;

`ifndef SYNTH
	// Between items the window must leave room for the next byte.
	a_window_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssr_pkg::ST_IDLE |-> cnt_q < CW'(MAXP))
		else $error("window full while waiting for input");

	// No emitted byte may be left behind once an item is finished.
	a_hold_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssr_pkg::ST_IDLE |-> !hold_v_q)
		else $error("held byte lost at end of item");

	// An empty beat only ever closes a line.
	a_empty_is_eol: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !ohas_q |-> ole_q && olast_q)
		else $error("empty beat that does not end a line");

	// The end of a line is always the end of a run.
	a_eol_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && ole_q |-> olast_q)
		else $error("line end on a beat that is not last of its run");
`endif

endmodule

`default_nettype wire
